/* rtl/core/dep_pkg.sv */
// dep_pkg: shared types, constants and helpers of the double-ended priority queue
// used by dep_heap_cell, double_ended_priority_queue, dep_checker and tb_top
`timescale 1ns / 1ps
`default_nettype none

package dep_pkg;

  localparam int CAPACITY = 1024;
  localparam int AW       = $clog2(CAPACITY);
  localparam int CW       = $clog2(CAPACITY + 1);
  localparam int LW       = AW + 2;
  localparam int ID_W     = 20;
  localparam int PRI_W    = 24;
  localparam int TYPE_W   = 2;
  localparam int STATUS_W = 2;

  localparam logic [CW-1:0] CAP_COUNT = CW'(CAPACITY);

  localparam logic [TYPE_W-1:0] REQ_INSERT  = 2'd0;
  localparam logic [TYPE_W-1:0] REQ_EXT_MAX = 2'd1;
  localparam logic [TYPE_W-1:0] REQ_EXT_MIN = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [PRI_W-1:0] pri;
  } dep_entry_t;

  typedef struct packed {
    logic [TYPE_W-1:0] req_type;
    logic [ID_W-1:0]   client_id;
    logic [PRI_W-1:0]  priority_req;
  } dep_req_t;

  typedef struct packed {
    logic [ID_W-1:0]     result_id;
    logic [STATUS_W-1:0] status;
  } dep_rsp_t;

  typedef enum logic [1:0] {
    OP_INSERT,
    OP_TOP,
    OP_DELETE
  } dep_op_t;

  typedef struct packed {
    logic       valid;
    dep_op_t    op;
    dep_entry_t entry;
  } dep_cmd_t;

  typedef struct packed {
    logic            busy;
    logic [CW-1:0]   count;
    logic [ID_W-1:0] root_id;
  } dep_stat_t;

  typedef enum logic [3:0] {
    C_IDLE,
    C_TOP,
    C_SCAN,
    C_RM_START,
    C_RM_LAST,
    C_UP_RD,
    C_UP_CMP,
    C_DN_RDL,
    C_DN_RDR,
    C_DN_CMPR,
    C_FIN
  } dep_cell_state_t;

  typedef enum logic [2:0] {
    T_IDLE,
    T_INS,
    T_SRC,
    T_DEL,
    T_RESP
  } dep_top_state_t;

  // a belongs above b in a heap of the given kind
  function automatic logic above(dep_entry_t a, dep_entry_t b, logic is_max);
    return is_max ? (a.pri > b.pri) : (a.pri < b.pri);
  endfunction

endpackage

`default_nettype wire

/* rtl/core/double_ended_priority_queue.sv */
// double_ended_priority_queue: top level, request sequencer and the two heap cells
// depends on dep_pkg and dep_heap_cell
//
// Requests arrive on req_valid/req_ready with a dep_req_t payload: insert an
// (id, priority) entry, extract the highest or extract the lowest priority.
// Each request gives exactly one response on rsp_valid/rsp_ready (dep_rsp_t):
// the extracted id and a status of ok, empty or full.
// The block works on one request at a time. An insert walks the sift-up path
// of both heaps in parallel. An extract reads the root of one heap and sifts
// it down, then scans the other heap for the same id, one entry per cycle
// from the single ram read port, and repairs it. Empty, full and unused
// requests go straight to the response.
// The response sits in an output register; the next request is accepted
// while it waits, and that request stalls only when its own response is due.
// Reset empties both heaps at once; the heap rams need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module double_ended_priority_queue import dep_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     req_valid,
  output logic          req_ready,
  input  wire dep_req_t req_data,
  output logic          rsp_valid,
  input  wire logic     rsp_ready,
  output dep_rsp_t      rsp_data
);

  dep_top_state_t      state, state_next;
  dep_cmd_t            cmd_max, cmd_max_next;
  dep_cmd_t            cmd_min, cmd_min_next;
  logic                src_max, src_max_next;
  logic [ID_W-1:0]     res_id, res_id_next;
  logic [STATUS_W-1:0] res_status, res_status_next;
  logic                rsp_valid_next;
  dep_rsp_t            rsp_data_next;

  dep_stat_t           max_stat;
  dep_stat_t           min_stat;
  logic                cmd_pending;
  logic                src_busy;
  logic [ID_W-1:0]     src_root;
  dep_entry_t          ins_entry;
  dep_entry_t          del_entry;

  dep_heap_cell u_max_cell (
    .clk      (clk),
    .rst      (rst),
    .max_mode (1'b1),
    .cmd      (cmd_max),
    .stat     (max_stat)
  );

  dep_heap_cell u_min_cell (
    .clk      (clk),
    .rst      (rst),
    .max_mode (1'b0),
    .cmd      (cmd_min),
    .stat     (min_stat)
  );

  assign cmd_pending   = cmd_max.valid | cmd_min.valid;
  assign src_busy      = src_max ? max_stat.busy : min_stat.busy;
  assign src_root      = src_max ? max_stat.root_id : min_stat.root_id;
  assign ins_entry.id  = req_data.client_id;
  assign ins_entry.pri = req_data.priority_req;
  assign del_entry.id  = src_root;
  assign del_entry.pri = '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= T_IDLE;
      cmd_max.valid <= 1'b0;
      cmd_min.valid <= 1'b0;
      rsp_valid     <= 1'b0;
    end else begin
      state     <= state_next;
      cmd_max   <= cmd_max_next;
      cmd_min   <= cmd_min_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    src_max    <= src_max_next;
    res_id     <= res_id_next;
    res_status <= res_status_next;
    rsp_data   <= rsp_data_next;
  end

  always_comb begin
    state_next         = state;
    cmd_max_next       = cmd_max;
    cmd_max_next.valid = 1'b0;
    cmd_min_next       = cmd_min;
    cmd_min_next.valid = 1'b0;
    src_max_next       = src_max;
    res_id_next        = res_id;
    res_status_next    = res_status;
    rsp_valid_next     = rsp_valid & ~rsp_ready;
    rsp_data_next      = rsp_data;
    req_ready          = 1'b0;

    case (state)
      T_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          res_id_next     = '0;
          res_status_next = STATUS_OK;
          case (req_data.req_type)
            REQ_INSERT: begin
              if ((max_stat.count >= CAP_COUNT) || (min_stat.count >= CAP_COUNT)) begin
                res_status_next = STATUS_FULL;
                state_next      = T_RESP;
              end else begin
                cmd_max_next.valid = 1'b1;
                cmd_max_next.op    = OP_INSERT;
                cmd_max_next.entry = ins_entry;
                cmd_min_next.valid = 1'b1;
                cmd_min_next.op    = OP_INSERT;
                cmd_min_next.entry = ins_entry;
                state_next         = T_INS;
              end
            end
            REQ_EXT_MAX: begin
              if (max_stat.count == '0) begin
                res_status_next = STATUS_EMPTY;
                state_next      = T_RESP;
              end else begin
                cmd_max_next.valid = 1'b1;
                cmd_max_next.op    = OP_TOP;
                src_max_next       = 1'b1;
                state_next         = T_SRC;
              end
            end
            REQ_EXT_MIN: begin
              if (min_stat.count == '0) begin
                res_status_next = STATUS_EMPTY;
                state_next      = T_RESP;
              end else begin
                cmd_min_next.valid = 1'b1;
                cmd_min_next.op    = OP_TOP;
                src_max_next       = 1'b0;
                state_next         = T_SRC;
              end
            end
            default: begin
              state_next = T_RESP;
            end
          endcase
        end
      end
      T_INS: begin
        if (!cmd_pending && !max_stat.busy && !min_stat.busy) begin
          state_next = T_RESP;
        end
      end
      T_SRC: begin
        if (!cmd_pending && !src_busy) begin
          res_id_next = src_root;
          if (src_max) begin
            cmd_min_next.valid = 1'b1;
            cmd_min_next.op    = OP_DELETE;
            cmd_min_next.entry = del_entry;
          end else begin
            cmd_max_next.valid = 1'b1;
            cmd_max_next.op    = OP_DELETE;
            cmd_max_next.entry = del_entry;
          end
          state_next = T_DEL;
        end
      end
      T_DEL: begin
        if (!cmd_pending && !max_stat.busy && !min_stat.busy) begin
          state_next = T_RESP;
        end
      end
      T_RESP: begin
        if (!rsp_valid || rsp_ready) begin
          rsp_valid_next          = 1'b1;
          rsp_data_next.result_id = res_id;
          rsp_data_next.status    = res_status;
          state_next              = T_IDLE;
        end
      end
      default: begin
        state_next = T_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/core/dep_ram.sv */
// dep_ram: generic simple dual-port ram, one write and one registered read port
// no package dependency
`timescale 1ns / 1ps
`default_nettype none

module dep_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 44
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* rtl/core/dep_heap_cell.sv */
// dep_heap_cell: one heap of the queue with its ram, sift engine and id scan
// depends on dep_pkg and dep_ram
`timescale 1ns / 1ps
`default_nettype none

module dep_heap_cell import dep_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      max_mode,
  input  wire dep_cmd_t  cmd,
  output dep_stat_t      stat
);

  dep_cell_state_t state, state_next;
  logic [CW-1:0]   count, count_next;
  logic [AW-1:0]   hole, hole_next;
  dep_entry_t      cur, cur_next;
  logic            moved, moved_next;
  logic [ID_W-1:0] key, key_next;
  logic [AW-1:0]   target, target_next;
  logic [CW-1:0]   scan_k, scan_k_next;
  logic [AW-1:0]   rd_idx, rd_idx_next;
  logic            rd_vld, rd_vld_next;
  logic [AW-1:0]   l_idx, l_idx_next;
  logic [AW-1:0]   best_idx, best_idx_next;
  dep_entry_t      best_val, best_val_next;
  logic            best_child, best_child_next;
  logic [ID_W-1:0] root_id, root_id_next;

  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  dep_entry_t      mem_wdata;
  logic [AW-1:0]   mem_raddr;
  dep_entry_t      rdata;

  logic [AW-1:0]   parent;
  logic [CW-1:0]   last_full;
  logic [AW-1:0]   last_idx;
  logic [LW-1:0]   l_wide;
  logic [LW-1:0]   r_wide;
  logic [LW-1:0]   count_wide;
  logic            has_r;
  logic            left_better;
  logic            right_better;

  logic            dec_go;
  logic            dec_child;
  logic [AW-1:0]   dec_idx;
  dep_entry_t      dec_val;

  dep_ram #(
    .DEPTH (CAPACITY),
    .WIDTH ($bits(dep_entry_t))
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (rdata)
  );

  assign parent       = (hole - AW'(1)) >> 1;
  assign last_full    = count - CW'(1);
  assign last_idx     = last_full[AW-1:0];
  assign l_wide       = LW'({hole, 1'b1});
  assign r_wide       = LW'(l_idx) + LW'(1);
  assign count_wide   = LW'(count);
  assign has_r        = r_wide < count_wide;
  assign left_better  = above(rdata, cur, max_mode);
  assign right_better = above(rdata, best_val, max_mode);

  assign stat.busy    = (state != C_IDLE);
  assign stat.count   = count;
  assign stat.root_id = root_id;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= C_IDLE;
      count  <= '0;
      rd_vld <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      rd_vld <= rd_vld_next;
    end
  end

  always_ff @(posedge clk) begin
    hole       <= hole_next;
    cur        <= cur_next;
    moved      <= moved_next;
    key        <= key_next;
    target     <= target_next;
    scan_k     <= scan_k_next;
    rd_idx     <= rd_idx_next;
    l_idx      <= l_idx_next;
    best_idx   <= best_idx_next;
    best_val   <= best_val_next;
    best_child <= best_child_next;
    root_id    <= root_id_next;
  end

  always_comb begin
    state_next      = state;
    count_next      = count;
    hole_next       = hole;
    cur_next        = cur;
    moved_next      = moved;
    key_next        = key;
    target_next     = target;
    scan_k_next     = scan_k;
    rd_idx_next     = rd_idx;
    rd_vld_next     = rd_vld;
    l_idx_next      = l_idx;
    best_idx_next   = best_idx;
    best_val_next   = best_val;
    best_child_next = best_child;
    root_id_next    = root_id;
    mem_we          = 1'b0;
    mem_waddr       = hole;
    mem_wdata       = cur;
    mem_raddr       = '0;
    dec_go          = 1'b0;
    dec_child       = 1'b0;
    dec_idx         = hole;
    dec_val         = cur;

    case (state)
      C_IDLE: begin
        if (cmd.valid) begin
          case (cmd.op)
            OP_INSERT: begin
              cur_next   = cmd.entry;
              hole_next  = count[AW-1:0];
              count_next = count + CW'(1);
              moved_next = 1'b1;
              state_next = C_UP_RD;
            end
            OP_TOP: begin
              state_next = C_TOP;
            end
            OP_DELETE: begin
              key_next    = cmd.entry.id;
              scan_k_next = '0;
              rd_vld_next = 1'b0;
              state_next  = C_SCAN;
            end
            default: begin
              state_next = C_IDLE;
            end
          endcase
        end
      end
      C_TOP: begin
        root_id_next = rdata.id;
        target_next  = '0;
        state_next   = C_RM_START;
      end
      C_SCAN: begin
        if (rd_vld && (rdata.id == key)) begin
          target_next = rd_idx;
          rd_vld_next = 1'b0;
          state_next  = C_RM_START;
        end else if (scan_k < count) begin
          mem_raddr   = scan_k[AW-1:0];
          rd_idx_next = scan_k[AW-1:0];
          rd_vld_next = 1'b1;
          scan_k_next = scan_k + CW'(1);
        end else begin
          rd_vld_next = 1'b0;
          state_next  = C_IDLE;
        end
      end
      C_RM_START: begin
        count_next = last_full;
        if (target == last_idx) begin
          state_next = C_IDLE;
        end else begin
          mem_raddr  = last_idx;
          state_next = C_RM_LAST;
        end
      end
      C_RM_LAST: begin
        cur_next   = rdata;
        hole_next  = target;
        moved_next = 1'b0;
        state_next = C_UP_RD;
      end
      C_UP_RD: begin
        if (hole == '0) begin
          state_next = moved ? C_FIN : C_DN_RDL;
        end else begin
          mem_raddr  = parent;
          state_next = C_UP_CMP;
        end
      end
      C_UP_CMP: begin
        if (above(cur, rdata, max_mode)) begin
          mem_we     = 1'b1;
          mem_waddr  = hole;
          mem_wdata  = rdata;
          hole_next  = parent;
          moved_next = 1'b1;
          state_next = C_UP_RD;
        end else begin
          state_next = moved ? C_FIN : C_DN_RDL;
        end
      end
      C_DN_RDL: begin
        if (l_wide >= count_wide) begin
          state_next = C_FIN;
        end else begin
          mem_raddr  = l_wide[AW-1:0];
          l_idx_next = l_wide[AW-1:0];
          state_next = C_DN_RDR;
        end
      end
      C_DN_RDR: begin
        if (left_better) begin
          best_idx_next   = l_idx;
          best_val_next   = rdata;
          best_child_next = 1'b1;
        end else begin
          best_idx_next   = hole;
          best_val_next   = cur;
          best_child_next = 1'b0;
        end
        if (has_r) begin
          mem_raddr  = r_wide[AW-1:0];
          state_next = C_DN_CMPR;
        end else begin
          dec_go    = 1'b1;
          dec_child = left_better;
          dec_idx   = left_better ? l_idx : hole;
          dec_val   = left_better ? rdata : cur;
        end
      end
      C_DN_CMPR: begin
        dec_go = 1'b1;
        if (right_better) begin
          dec_child = 1'b1;
          dec_idx   = r_wide[AW-1:0];
          dec_val   = rdata;
        end else begin
          dec_child = best_child;
          dec_idx   = best_idx;
          dec_val   = best_val;
        end
      end
      C_FIN: begin
        mem_we     = 1'b1;
        mem_waddr  = hole;
        mem_wdata  = cur;
        state_next = C_IDLE;
      end
      default: begin
        state_next = C_IDLE;
      end
    endcase

    // sift-down step: move the better child into the hole or stop
    if (dec_go) begin
      if (dec_child) begin
        mem_we     = 1'b1;
        mem_waddr  = hole;
        mem_wdata  = dec_val;
        hole_next  = dec_idx;
        state_next = C_DN_RDL;
      end else begin
        state_next = C_FIN;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/dep_checker.sv */
// dep_checker: port-level assertions for the double-ended priority queue
// depends on dep_pkg; bound to double_ended_priority_queue
`timescale 1ns / 1ps
`default_nettype none

module dep_checker import dep_pkg::*; (
  input wire logic     clk,
  input wire logic     rst,
  input wire logic     req_valid,
  input wire logic     req_ready,
  input wire logic     rsp_valid,
  input wire logic     rsp_ready,
  input wire dep_rsp_t rsp_data
);

  // a stalled response holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
    else $error("response changed while stalled");

  // empty and full answers carry id zero
  a_id_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp_data.status != STATUS_OK)) |-> (rsp_data.result_id == '0))
    else $error("non-ok response with nonzero id");

  // one request in work at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("request accepted while busy");

  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid after reset");

endmodule

bind double_ended_priority_queue dep_checker u_dep_checker (.*);

`default_nettype wire

/* test/tb_top.sv */
// tb_top: self-checking testbench for double_ended_priority_queue
// drives dep_req_t requests, checks dep_rsp_t responses against a twin-heap predictor
// depends on dep_pkg and the double_ended_priority_queue rtl
`timescale 1ns / 1ps

module tb_top;
  import dep_pkg::*;

  localparam logic [TYPE_W-1:0] REQ_UNUSED = 2'd3;
  localparam int HI = 0;
  localparam int LO = 1;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     req_valid = 1'b0;
  logic     req_ready;
  dep_req_t req_data = '0;
  logic     rsp_valid;
  logic     rsp_ready = 1'b0;
  dep_rsp_t rsp_data;

  int send_idle_pct = 0;
  int take_stall_pct = 0;
  int errs = 0;

  // heap images: index HI is the max side, LO the min side
  dep_entry_t  heap_q [2][CAPACITY];
  int unsigned heap_n [2];
  dep_rsp_t    owed_rsp[$];

  typedef struct {
    dep_req_t req;
    logic     pinned;
    dep_rsp_t rsp;
  } row_t;

  row_t rows[$];

  double_ended_priority_queue dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  function automatic logic outranks(int s, dep_entry_t a, dep_entry_t b);
    if (s == HI) return a.pri > b.pri;
    return a.pri < b.pri;
  endfunction

  function automatic void swap_at(int s, int unsigned a, int unsigned b);
    dep_entry_t t;
    t = heap_q[s][a];
    heap_q[s][a] = heap_q[s][b];
    heap_q[s][b] = t;
  endfunction

  function automatic logic bubble_up(int s, int unsigned i);
    int unsigned p;
    logic moved;
    moved = 1'b0;
    while (i > 0) begin
      p = (i - 1) / 2;
      if (!outranks(s, heap_q[s][i], heap_q[s][p])) break;
      swap_at(s, i, p);
      i = p;
      moved = 1'b1;
    end
    return moved;
  endfunction

  function automatic void bubble_down(int s, int unsigned i);
    int unsigned l, r, best, n;
    n = heap_n[s];
    while (i < n) begin
      l = 2 * i + 1;
      r = l + 1;
      best = i;
      if (l < n && outranks(s, heap_q[s][l], heap_q[s][best])) best = l;
      if (r < n && outranks(s, heap_q[s][r], heap_q[s][best])) best = r;
      if (best == i) break;
      swap_at(s, i, best);
      i = best;
    end
  endfunction

  // remove slot i, refill from the tail and repair in either direction
  function automatic void drop_slot(int s, int unsigned i);
    if (heap_n[s] == 0 || i >= heap_n[s]) return;
    heap_n[s] = heap_n[s] - 1;
    if (i == heap_n[s]) return;
    heap_q[s][i] = heap_q[s][heap_n[s]];
    if (!bubble_up(s, i)) bubble_down(s, i);
  endfunction

  // take the root of one side, then delete the first same id on the other side
  function automatic logic [ID_W-1:0] pop_side(int s);
    logic [ID_W-1:0] id;
    int unsigned i;
    int o;
    o = 1 - s;
    id = heap_q[s][0].id;
    drop_slot(s, 0);
    for (i = 0; i < heap_n[o]; i++) begin
      if (heap_q[o][i].id == id) begin
        drop_slot(o, i);
        break;
      end
    end
    return id;
  endfunction

  function automatic dep_rsp_t apply_request(dep_req_t r);
    dep_rsp_t o;
    dep_entry_t e;
    int s;
    o.result_id = '0;
    o.status = STATUS_OK;
    case (r.req_type)
      REQ_INSERT: begin
        if (heap_n[HI] >= CAPACITY || heap_n[LO] >= CAPACITY) begin
          o.status = STATUS_FULL;
        end else begin
          e.id = r.client_id;
          e.pri = r.priority_req;
          for (s = 0; s < 2; s++) begin
            heap_q[s][heap_n[s]] = e;
            void'(bubble_up(s, heap_n[s]));
            heap_n[s] = heap_n[s] + 1;
          end
        end
      end
      REQ_EXT_MAX: begin
        if (heap_n[HI] == 0) o.status = STATUS_EMPTY;
        else o.result_id = pop_side(HI);
      end
      REQ_EXT_MIN: begin
        if (heap_n[LO] == 0) o.status = STATUS_EMPTY;
        else o.result_id = pop_side(LO);
      end
      default: ;
    endcase
    return o;
  endfunction

  function automatic dep_req_t rand_req(int ins_pct);
    dep_req_t r;
    int k;
    k = $urandom_range(99);
    if (k < ins_pct) r.req_type = REQ_INSERT;
    else if (k < 97 - (97 - ins_pct) / 2) r.req_type = REQ_EXT_MAX;
    else if (k < 97) r.req_type = REQ_EXT_MIN;
    else r.req_type = REQ_UNUSED;
    // small id pool for duplicates, small priority ranges for ties
    if ($urandom_range(3) == 0) r.client_id = ID_W'($urandom_range(7));
    else r.client_id = ID_W'($urandom());
    case ($urandom_range(3))
      0: r.priority_req = PRI_W'($urandom_range(3));
      1: r.priority_req = 24'hFFFFFF - PRI_W'($urandom_range(3));
      default: r.priority_req = PRI_W'($urandom());
    endcase
    return r;
  endfunction

  function automatic void add_row(logic [TYPE_W-1:0] t, logic [ID_W-1:0] id,
                                  logic [PRI_W-1:0] pri, logic pinned,
                                  logic [ID_W-1:0] rid, logic [STATUS_W-1:0] st);
    row_t w;
    w.req.req_type = t;
    w.req.client_id = id;
    w.req.priority_req = pri;
    w.pinned = pinned;
    w.rsp.result_id = rid;
    w.rsp.status = st;
    rows.push_back(w);
  endfunction

  task automatic set_mode(int m);
    case (m)
      0: begin send_idle_pct = 0;  take_stall_pct <= 0;  end
      1: begin send_idle_pct = 87; take_stall_pct <= 0;  end
      2: begin send_idle_pct = 0;  take_stall_pct <= 87; end
      default: begin send_idle_pct = 18; take_stall_pct <= 18; end
    endcase
  endtask

  // called at a clock edge; returns at the edge where the request transfer happens
  task automatic send_req(dep_req_t r, logic pinned, dep_rsp_t pin_rsp);
    dep_rsp_t calc;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    req_valid <= 1'b1;
    req_data <= r;
    do @(posedge clk); while (!req_ready);
    calc = apply_request(r);
    owed_rsp.push_back(pinned ? pin_rsp : calc);
  endtask

  task automatic send_rand(int ins_pct);
    send_req(rand_req(ins_pct), 1'b0, '0);
  endtask

  // hold off until every outstanding response is back
  task automatic drain();
    req_valid <= 1'b0;
    while (owed_rsp.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    rsp_ready <= rst ? 1'b0 : ($urandom_range(99) >= take_stall_pct);
  end

  always @(posedge clk) begin
    dep_rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (owed_rsp.size() == 0) begin
        $error("unexpected response: result_id %h status %0d",
               rsp_data.result_id, rsp_data.status);
        errs++;
      end else begin
        want = owed_rsp.pop_front();
        if (rsp_data.result_id !== want.result_id) begin
          $error("result_id: expected %h, got %h", want.result_id, rsp_data.result_id);
          errs++;
        end
        if (rsp_data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp_data.status);
          errs++;
        end
      end
    end
  end

  initial begin
    #8_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

  initial begin
    int m, i;
    heap_n[HI] = 0;
    heap_n[LO] = 0;

    // empty queue, unused code, extremes, ties and duplicate ids
    add_row(REQ_EXT_MAX, '0, '0, 1'b1, '0, STATUS_EMPTY);
    add_row(REQ_EXT_MIN, '0, '0, 1'b1, '0, STATUS_EMPTY);
    add_row(REQ_UNUSED, '0, '0, 1'b1, '0, STATUS_OK);
    add_row(REQ_INSERT, 20'hFFFFF, 24'hFFFFFF, 1'b1, '0, STATUS_OK);
    add_row(REQ_INSERT, '0, '0, 1'b1, '0, STATUS_OK);
    add_row(REQ_EXT_MAX, '0, '0, 1'b1, 20'hFFFFF, STATUS_OK);
    add_row(REQ_EXT_MIN, '0, '0, 1'b1, '0, STATUS_OK);
    add_row(REQ_EXT_MIN, '0, '0, 1'b1, '0, STATUS_EMPTY);
    add_row(REQ_INSERT, 20'd5, 24'd100, 1'b0, '0, STATUS_OK);
    add_row(REQ_INSERT, 20'd5, 24'd1, 1'b0, '0, STATUS_OK);
    add_row(REQ_INSERT, 20'd7, 24'd100, 1'b0, '0, STATUS_OK);
    add_row(REQ_INSERT, 20'd8, 24'd50, 1'b0, '0, STATUS_OK);
    add_row(REQ_EXT_MAX, 20'hFFFFF, 24'hFFFFFF, 1'b0, '0, STATUS_OK);
    add_row(REQ_EXT_MIN, '0, '0, 1'b0, '0, STATUS_OK);
    add_row(REQ_EXT_MAX, '0, '0, 1'b0, '0, STATUS_OK);
    add_row(REQ_INSERT, 20'hAAAAA, 24'h555555, 1'b0, '0, STATUS_OK);
    add_row(REQ_INSERT, 20'h55555, 24'hAAAAAA, 1'b0, '0, STATUS_OK);
    add_row(REQ_UNUSED, 20'hFFFFF, 24'hFFFFFF, 1'b1, '0, STATUS_OK);
    add_row(REQ_EXT_MIN, '0, '0, 1'b0, '0, STATUS_OK);
    add_row(REQ_EXT_MAX, '0, '0, 1'b0, '0, STATUS_OK);
    add_row(REQ_EXT_MIN, '0, '0, 1'b0, '0, STATUS_OK);
    add_row(REQ_EXT_MAX, '0, '0, 1'b0, '0, STATUS_OK);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < rows.size(); i++) send_req(rows[i].req, rows[i].pinned, rows[i].rsp);
    drain();

    // random traffic: grow the queue, then wear it down, under each idle pattern
    for (m = 0; m < 4; m++) begin
      set_mode(m);
      for (i = 0; i < 130; i++) send_rand(i < 80 ? 70 : 40);
      drain();
    end

    set_mode(0);
    repeat (100) @(posedge clk);
    if (errs == 0) $display("tb_top OK");
    else $display("tb_top NOT OK");
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/dep_pkg.sv
rtl/core/dep_ram.sv
rtl/core/dep_heap_cell.sv
rtl/core/double_ended_priority_queue.sv
rtl/core/dep_checker.sv
test/tb_top.sv
